[rtl/core/vhp_pkg.sv]
`timescale 1ns / 1ps

package vhp_pkg;

	localparam int MAX_FRAME   = 2048;
	localparam int FRAME_W     = $clog2(MAX_FRAME + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BADLEN   = 3'd1,
		ST_BADID    = 3'd2,
		ST_BADNEXT  = 3'd3,
		ST_TOOLONG  = 3'd4,
		ST_UNDERRUN = 3'd5
	} status_t;

	// classified byte as it travels from the front end to the parser
	typedef struct packed {
		logic       cont;
		logic [6:0] group;
	} entry_t;

endpackage

[rtl/core/vhp_front.sv]
`timescale 1ns / 1ps

module vhp_front import vhp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	output logic       push,
	output entry_t     push_entry,
	input  logic       q_full
);

	logic   valid_s1;
	entry_t entry_s1;

	assign push       = valid_s1 && !q_full;
	assign push_entry = entry_s1;
	assign in_stall   = valid_s1 && q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			entry_s1 <= '0;
		end else if (!in_stall) begin
			valid_s1       <= in_valid;
			entry_s1.cont  <= data_byte[7];
			entry_s1.group <= data_byte[6:0];
		end
	end

endmodule

[rtl/core/vhp_queue.sv]
`timescale 1ns / 1ps

module vhp_queue import vhp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   q_full,
	input  logic   pop,
	output logic   q_valid,
	output entry_t pop_entry
);

	entry_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_pop;

	assign q_full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_valid   = (count_q != '0);
	assign pop_entry = mem_q[rd_ptr_q];
	assign do_pop    = pop && q_valid;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/core/vhp_back.sv]
`timescale 1ns / 1ps

module vhp_back import vhp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  entry_t             pop_entry,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic signed [31:0] client_version,
	output logic [1:0]         requested_state
);

	typedef enum logic [2:0] {
		PH_LEN, PH_PID, PH_VER, PH_SLEN, PH_SKIP, PH_PORT, PH_NEXT, PH_TAIL
	} phase_t;

	phase_t               phase_q, phase_n;
	logic [31:0]          acc_q, acc_n;
	logic [2:0]           cnt_q, cnt_n;
	logic [FRAME_W-1:0]   left_q, left_n;
	logic [31:0]          skip_q, skip_n;
	status_t              perr_q, perr_n;
	logic [31:0]          ver_q, ver_n;
	logic [1:0]           ns_q, ns_n;

	logic                 out_valid_q;
	status_t              status_q;
	logic [31:0]          version_q;
	logic [1:0]           req_q;

	logic [31:0]          contrib;
	logic [31:0]          v;
	logic [2:0]           cnt_inc;
	logic                 done;
	logic                 toolong;
	logic                 emit;
	logic                 clr_all;
	status_t              em_status;
	logic [31:0]          em_ver;
	logic [1:0]           em_ns;

	assign pop              = q_valid && (!out_valid_q || !out_stall);
	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign client_version   = version_q;
	assign requested_state  = req_q;

	always_comb begin
		case (cnt_q)
			3'd0:    contrib = {25'b0, pop_entry.group};
			3'd1:    contrib = {18'b0, pop_entry.group, 7'b0};
			3'd2:    contrib = {11'b0, pop_entry.group, 14'b0};
			3'd3:    contrib = {4'b0, pop_entry.group, 21'b0};
			default: contrib = {pop_entry.group[3:0], 28'b0};
		endcase
		v       = acc_q | contrib;
		cnt_inc = cnt_q + 3'd1;
		done    = !pop_entry.cont;
		toolong = pop_entry.cont && (cnt_inc >= 3'd5);
	end

	always_comb begin
		phase_n   = phase_q;
		acc_n     = acc_q;
		cnt_n     = cnt_q;
		left_n    = left_q;
		skip_n    = skip_q;
		perr_n    = perr_q;
		ver_n     = ver_q;
		ns_n      = ns_q;
		emit      = 1'b0;
		clr_all   = 1'b0;
		em_status = ST_OK;
		em_ver    = '0;
		em_ns     = '0;

		if (phase_q == PH_LEN) begin
			if (toolong) begin
				emit      = 1'b1;
				em_status = ST_TOOLONG;
				clr_all   = 1'b1;
			end else if (done) begin
				if (v == 32'd0 || v > 32'(MAX_FRAME)) begin
					emit      = 1'b1;
					em_status = ST_BADLEN;
					clr_all   = 1'b1;
				end else begin
					left_n  = v[FRAME_W-1:0];
					skip_n  = '0;
					perr_n  = ST_OK;
					ver_n   = '0;
					ns_n    = '0;
					acc_n   = '0;
					cnt_n   = '0;
					phase_n = PH_PID;
				end
			end else begin
				acc_n = v;
				cnt_n = cnt_inc;
			end
		end else begin
			if (left_q != '0)
				left_n = left_q - 1'b1;

			case (phase_q)
				PH_PID, PH_VER, PH_SLEN, PH_NEXT: begin
					if (toolong) begin
						if (perr_q == ST_OK)
							perr_n = ST_TOOLONG;
						phase_n = PH_TAIL;
						acc_n   = '0;
						cnt_n   = '0;
					end else if (!done) begin
						acc_n = v;
						cnt_n = cnt_inc;
					end else begin
						acc_n = '0;
						cnt_n = '0;
						case (phase_q)
							PH_PID: begin
								if (v != 32'd0) begin
									if (perr_q == ST_OK)
										perr_n = ST_BADID;
									phase_n = PH_TAIL;
								end else begin
									phase_n = PH_VER;
								end
							end
							PH_VER: begin
								ver_n   = v;
								phase_n = PH_SLEN;
							end
							PH_SLEN: begin
								if (v == 32'd0) begin
									skip_n  = 32'd2;
									phase_n = PH_PORT;
								end else begin
									skip_n  = v;
									phase_n = PH_SKIP;
								end
							end
							default: begin
								if (v == 32'd1 || v == 32'd2) begin
									ns_n    = v[1:0];
									phase_n = PH_TAIL;
								end else begin
									if (perr_q == ST_OK)
										perr_n = ST_BADNEXT;
									phase_n = PH_TAIL;
								end
							end
						endcase
					end
				end
				PH_SKIP: begin
					if (skip_q == 32'd0 || skip_q == 32'd1) begin
						skip_n  = 32'd2;
						phase_n = PH_PORT;
					end else begin
						skip_n = skip_q - 32'd1;
					end
				end
				PH_PORT: begin
					if (skip_q != 32'd0)
						skip_n = skip_q - 32'd1;
					if (skip_q == 32'd0 || skip_q == 32'd1)
						phase_n = PH_NEXT;
				end
				default: phase_n = PH_TAIL;
			endcase

			if (left_n == '0) begin
				emit    = 1'b1;
				clr_all = 1'b1;
				if (perr_n != ST_OK) begin
					em_status = perr_n;
				end else if (phase_n == PH_TAIL) begin
					em_status = ST_OK;
					em_ver    = ver_n;
					em_ns     = ns_n;
				end else begin
					em_status = ST_UNDERRUN;
				end
			end
		end

		if (clr_all) begin
			phase_n = PH_LEN;
			acc_n   = '0;
			cnt_n   = '0;
			left_n  = '0;
			skip_n  = '0;
			perr_n  = ST_OK;
			ver_n   = '0;
			ns_n    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEN;
			acc_q       <= '0;
			cnt_q       <= '0;
			left_q      <= '0;
			skip_q      <= '0;
			perr_q      <= ST_OK;
			ver_q       <= '0;
			ns_q        <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			version_q   <= '0;
			req_q       <= '0;
		end else begin
			if (pop) begin
				phase_q <= phase_n;
				acc_q   <= acc_n;
				cnt_q   <= cnt_n;
				left_q  <= left_n;
				skip_q  <= skip_n;
				perr_q  <= perr_n;
				ver_q   <= ver_n;
				ns_q    <= ns_n;
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
				status_q    <= em_status;
				version_q   <= em_ver;
				req_q       <= em_ns;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/core/varint_handshake_packet_parser.sv]
`timescale 1ns / 1ps

// Handshake frame parser. Takes one byte per transfer, one transfer per clock
// while in_stall is low; the byte that causes a result passes the front
// register, then the queue, then the parser output register. The front
// register classifies each byte, a four-entry queue decouples it from the
// parser, and the parser decodes one byte per cycle while the queue holds
// one and its output is not stalled. One result is given per frame: at once
// for a bad or over-long length prefix, otherwise on the last body byte.
// Status and fields stay until the output transfer completes.

module varint_handshake_packet_parser import vhp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic signed [31:0] client_version,
	output logic [1:0]         requested_state
);

	logic   push;
	entry_t push_entry;
	logic   q_full;
	logic   pop;
	logic   q_valid;
	entry_t pop_entry;

	vhp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	vhp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full),
		.pop        (pop),
		.q_valid    (q_valid),
		.pop_entry  (pop_entry)
	);

	vhp_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_valid          (q_valid),
		.pop_entry        (pop_entry),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.client_version   (client_version),
		.requested_state  (requested_state)
	);

endmodule

[bench/varint_handshake_packet_parser_tb.sv]
`timescale 1ns / 1ps

module varint_handshake_packet_parser_tb;
	import vhp_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 16;
	localparam int ITEM_TARGET  = 2000;

	typedef enum logic [2:0] {
		P_LEN, P_PID, P_VER, P_SLEN, P_SKIP, P_PORT, P_NEXT, P_TAIL
	} phase_t;

	typedef enum logic [1:0] {V_MORE, V_DONE, V_LONG} vstep_t;

	typedef struct packed {
		status_t     st;
		logic [31:0] ver;
		logic [1:0]  ns;
	} outcome_t;

	typedef struct packed {
		logic [3:0]  len;
		logic [55:0] bytes;
		logic        known;
		status_t     st;
		logic [31:0] ver;
		logic [1:0]  ns;
	} stim_row_t;

	localparam int N_DIR = 8;
	localparam stim_row_t DIR_ROWS [N_DIR] = '{
		'{4'd1, 56'h00,                   1'b1, ST_BADLEN,   32'd0, 2'd0},
		'{4'd2, 56'h81_10,                1'b1, ST_BADLEN,   32'd0, 2'd0},
		'{4'd5, 56'hFF_FF_FF_FF_0F,       1'b1, ST_BADLEN,   32'd0, 2'd0},
		'{4'd5, 56'h80_80_80_80_80,       1'b1, ST_TOOLONG,  32'd0, 2'd0},
		'{4'd2, 56'h01_05,                1'b1, ST_BADID,    32'd0, 2'd0},
		'{4'd2, 56'h01_00,                1'b1, ST_UNDERRUN, 32'd0, 2'd0},
		'{4'd7, 56'h06_00_05_00_63_DD_01, 1'b0, ST_OK,       32'd0, 2'd0},
		'{4'd7, 56'h06_00_05_00_00_00_03, 1'b1, ST_BADNEXT,  32'd0, 2'd0}
	};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         data_byte;
	logic               out_valid;
	logic               out_stall;
	logic [2:0]         status;
	logic signed [31:0] client_version;
	logic [1:0]         requested_state;

	varint_handshake_packet_parser dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.data_byte        (data_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.client_version   (client_version),
		.requested_state  (requested_state)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// parser state mirror
	phase_t      ph;
	logic [31:0] acc;
	logic [2:0]  vcnt;
	logic [31:0] frame_left;
	logic [31:0] skip_left;
	status_t     pend;
	logic [31:0] ver_l;
	logic [1:0]  ns_l;

	outcome_t    frame_outcomes [$];
	logic [7:0]  frame_q [$];

	int  mismatches;
	int  fed_items;
	int  frames_sent;
	int  ok_results;
	int  err_results;
	int  idle_cycles;
	bit  tx_calm;
	bit  rx_calm;
	bit  hold_req;

	task automatic report(input string what);
		mismatches++;
		if (mismatches <= 40)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	function automatic void restart_frame();
		ph = P_LEN;
		acc = '0;
		vcnt = '0;
		frame_left = '0;
		skip_left = '0;
		pend = ST_OK;
		ver_l = '0;
		ns_l = '0;
	endfunction

	function automatic vstep_t feed_group(input logic [7:0] b);
		int sh;
		sh = 7 * int'(vcnt);
		if (sh < 32)
			acc = acc | ({25'd0, b[6:0]} << sh);
		vcnt = vcnt + 3'd1;
		if (!b[7])
			return V_DONE;
		if (vcnt >= 3'd5)
			return V_LONG;
		return V_MORE;
	endfunction

	function automatic void body_err(input status_t e);
		if (pend == ST_OK)
			pend = e;
		ph = P_TAIL;
		acc = '0;
		vcnt = '0;
	endfunction

	function automatic bit parse_byte(input logic [7:0] b, output outcome_t r);
		vstep_t      v;
		logic [31:0] val;
		r = '0;
		if (ph == P_LEN) begin
			v = feed_group(b);
			if (v == V_MORE)
				return 1'b0;
			if (v == V_LONG) begin
				restart_frame();
				r.st = ST_TOOLONG;
				return 1'b1;
			end
			val = acc;
			acc = '0;
			vcnt = '0;
			if (val == 0 || val > MAX_FRAME) begin
				restart_frame();
				r.st = ST_BADLEN;
				return 1'b1;
			end
			frame_left = val;
			skip_left = '0;
			pend = ST_OK;
			ver_l = '0;
			ns_l = '0;
			ph = P_PID;
			return 1'b0;
		end
		if (frame_left != 0)
			frame_left--;
		case (ph)
			P_PID, P_VER, P_SLEN, P_NEXT: begin
				v = feed_group(b);
				if (v == V_LONG) begin
					body_err(ST_TOOLONG);
				end else if (v == V_DONE) begin
					val = acc;
					acc = '0;
					vcnt = '0;
					case (ph)
						P_PID: begin
							if (val != 0)
								body_err(ST_BADID);
							else
								ph = P_VER;
						end
						P_VER: begin
							ver_l = val;
							ph = P_SLEN;
						end
						P_SLEN: begin
							if (val == 0) begin
								skip_left = 32'd2;
								ph = P_PORT;
							end else begin
								skip_left = val;
								ph = P_SKIP;
							end
						end
						default: begin
							if (val == 1 || val == 2) begin
								ns_l = val[1:0];
								ph = P_TAIL;
							end else begin
								body_err(ST_BADNEXT);
							end
						end
					endcase
				end
			end
			P_SKIP: begin
				if (skip_left != 0)
					skip_left--;
				if (skip_left == 0) begin
					skip_left = 32'd2;
					ph = P_PORT;
				end
			end
			P_PORT: begin
				if (skip_left != 0)
					skip_left--;
				if (skip_left == 0)
					ph = P_NEXT;
			end
			default: ph = P_TAIL;
		endcase
		if (frame_left != 0)
			return 1'b0;
		if (pend != ST_OK)
			r.st = pend;
		else if (ph == P_TAIL)
			r.st = ST_OK;
		else
			r.st = ST_UNDERRUN;
		if (r.st == ST_OK) begin
			r.ver = ver_l;
			r.ns = ns_l;
		end
		restart_frame();
		return 1'b1;
	endfunction

	function automatic int pad_draw();
		return ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 4)) : 0;
	endfunction

	// LEB128 groups, optionally padded with redundant groups up to five; a fifth group gets random bits above bit 31
	function automatic void add_varint(input logic [31:0] v, input int extra);
		int         n;
		logic [7:0] g;
		n = 1;
		while (n < 5 && (v >> (7 * n)) != 0)
			n++;
		n = (n + extra > 5) ? 5 : n + extra;
		for (int i = 0; i < n; i++) begin
			g = {1'b0, 7'(v >> (7 * i))};
			if (i == 4)
				g[6:4] = 3'($urandom_range(0, 7));
			if (i < n - 1)
				g[7] = 1'b1;
			frame_q.push_back(g);
		end
	endfunction

	task automatic send(input logic [7:0] b, input bit known, input outcome_t known_res);
		int       gap;
		outcome_t r;
		gap = tx_calm ? 0 : int'($urandom_range(0, 6));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		if (parse_byte(b, r))
			frame_outcomes.push_back(known ? known_res : r);
	endtask

	task automatic random_frame(input bit long_frame);
		int          kind;
		int          L;
		int          p;
		logic [31:0] v;
		logic [7:0]  body_q [$];
		kind = $urandom_range(0, 99);
		frame_q.delete();
		if (kind >= 97) begin
			repeat ($urandom_range(1, 12))
				frame_q.push_back(8'($urandom()));
		end else if (kind >= 92) begin
			case ($urandom_range(0, 3))
				0: add_varint(32'd0, pad_draw());
				1: add_varint(32'($urandom_range(MAX_FRAME + 1, 4095)), pad_draw());
				2: add_varint(32'h8000_0000 | $urandom(), 0);
				default: repeat (5) frame_q.push_back({1'b1, 7'($urandom())});
			endcase
		end else begin
			add_varint((kind < 6) ? 32'($urandom_range(1, 127)) : 32'd0, pad_draw());
			case ($urandom_range(0, 5))
				0: v = 32'd0;
				1: v = 32'hFFFF_FFFF;
				2: v = 32'h8000_0000;
				3: v = 32'h7FFF_FFFF;
				default: v = $urandom() >> $urandom_range(0, 31);
			endcase
			add_varint(v, pad_draw());
			v = (kind inside {[6:9]}) ? ($urandom() | 32'h100) : 32'($urandom_range(0, 10));
			add_varint(v, pad_draw());
			if (v <= 40)
				repeat (v) frame_q.push_back(8'($urandom()));
			repeat (2) frame_q.push_back(8'($urandom()));
			if (kind inside {[10:17]}) begin
				case ($urandom_range(0, 3))
					0: v = 32'd0;
					1: v = 32'd3;
					2: v = 32'($urandom_range(4, 300));
					default: v = $urandom();
				endcase
			end else begin
				v = 32'($urandom_range(1, 2));
			end
			add_varint(v, pad_draw());
			repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom()));
			if (kind inside {[18:23]}) begin
				p = $urandom_range(0, frame_q.size());
				repeat (5) frame_q.insert(p, {1'b1, 7'($urandom())});
			end
			body_q = frame_q;
			frame_q.delete();
			L = body_q.size();
			if (long_frame)
				L = MAX_FRAME / 4;
			else if (kind inside {[24:31]})
				L = $urandom_range(1, L);
			else if (kind inside {[32:37]})
				L = L + int'($urandom_range(1, 6));
			add_varint(32'(L), pad_draw());
			for (int i = 0; i < L && i < body_q.size(); i++)
				frame_q.push_back(body_q[i]);
		end
		foreach (frame_q[i])
			send(frame_q[i], 1'b0, '0);
		fed_items += frame_q.size();
		// pad out whatever frame is still open
		while (ph != P_LEN || vcnt != 0) begin
			send(8'($urandom()), 1'b0, '0);
			fed_items++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles + 1 >= STALL_LIMIT) begin
				$display("[%0t] no transfer for %0d cycles", $realtime, STALL_LIMIT);
				$display("varint_handshake_packet_parser verification failed");
				$finish;
			end
		end
	end

	initial begin : sink
		int       w;
		outcome_t want;
		out_stall = 1'b0;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				w = HOLD_CYCLES;
			end else begin
				w = rx_calm ? 0 : int'($urandom_range(0, 6));
			end
			if (w > 0) begin
				out_stall <= 1'b1;
				repeat (w) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			if (status == ST_OK)
				ok_results++;
			else
				err_results++;
			if (frame_outcomes.size() == 0) begin
				report($sformatf("result with no frame pending, status %0d", status));
			end else begin
				want = frame_outcomes.pop_front();
				if (status !== want.st)
					report($sformatf("status %0d, expected %0d", status, want.st));
				if (client_version !== want.ver)
					report($sformatf("client_version %0h, expected %0h",
						client_version, want.ver));
				if (requested_state !== want.ns)
					report($sformatf("requested_state %0d, expected %0d",
						requested_state, want.ns));
			end
		end
	end

	initial begin
		stim_row_t row;
		int        frame_no;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		idle_cycles = 0;
		mismatches = 0;
		fed_items = 0;
		ok_results = 0;
		err_results = 0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		hold_req = 1'b0;
		restart_frame();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < N_DIR; r++) begin
			row = DIR_ROWS[r];
			for (int i = 0; i < row.len; i++)
				send(row.bytes[8 * (row.len - 1 - i) +: 8], row.known && i == row.len - 1,
					'{row.st, row.ver, row.ns});
			fed_items += row.len;
		end

		frame_no = 0;
		while (fed_items < ITEM_TARGET) begin
			if (frame_no % 16 == 0) begin
				tx_calm = ($urandom_range(0, 3) == 0);
				rx_calm = ($urandom_range(0, 3) == 0);
			end
			if (frame_no == 40) begin
				// receiver holds off while short error frames keep coming
				hold_req = 1'b1;
				tx_calm = 1'b1;
				repeat (30)
					send(8'h00, 1'b0, '0);
				fed_items += 30;
			end
			random_frame(frame_no == 25);
			frame_no++;
		end
		frames_sent = frame_no;
		in_valid <= 1'b0;

		while (frame_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("fed %0d frame bytes over %0d directed rows and %0d random frames",
			fed_items, N_DIR, frames_sent);
		$display("results checked: %0d ok, %0d with an error status, %0d mismatches",
			ok_results, err_results, mismatches);
		if (mismatches == 0)
			$display("varint_handshake_packet_parser verification clean");
		else
			$display("varint_handshake_packet_parser verification failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/vhp_pkg.sv
rtl/core/vhp_front.sv
rtl/core/vhp_queue.sv
rtl/core/vhp_back.sv
rtl/core/varint_handshake_packet_parser.sv
bench/varint_handshake_packet_parser_tb.sv
